[sv/gimli_pkg.sv]
// Gimli hash package: state type, sizes and constants shared by the round unit,
// the sponge top level and the testbench. No dependencies.
package gimli_pkg;

	localparam int unsigned WORDS     = 12;
	localparam int unsigned RATE_B    = 16;
	localparam int unsigned RND_W     = 5;   // round numbers run up to 24
	localparam int unsigned CNT_W     = 6;   // digest byte index, 0..63
	localparam int unsigned HLEN_W    = 7;
	localparam int unsigned MAX_DIG   = 64;

	localparam logic [31:0] RC        = 32'h9e37_7900;
	localparam logic [7:0]  PAD_FIRST = 8'h1F;
	localparam logic [7:0]  PAD_LAST  = 8'h80;
	localparam logic [3:0]  LAST_POS  = 4'd15;

	typedef logic [WORDS-1:0][31:0] state_t;

	// xor one byte into the rate, little-endian within each word
	function automatic state_t xor_byte(input state_t s, input logic [3:0] pos,
			input logic [7:0] v);
		state_t r;
		r = s;
		r[pos[3:2]][{pos[1:0], 3'b000} +: 8] = s[pos[3:2]][{pos[1:0], 3'b000} +: 8] ^ v;
		return r;
	endfunction

	function automatic state_t pad(input state_t s, input logic [3:0] pos);
		return xor_byte(xor_byte(s, pos, PAD_FIRST), LAST_POS, PAD_LAST);
	endfunction

endpackage

[sv/gimli_round.sv]
// One Gimli round: SP-box over the four columns, then the small or big swap
// and the round constant as the round number selects. Uses gimli_pkg.
module gimli_round (
	input  gimli_pkg::state_t                 st_in,
	input  logic [gimli_pkg::RND_W-1:0]       rnd,
	output gimli_pkg::state_t                 st_out
);

	gimli_pkg::state_t sp;

	always_comb begin
		logic [31:0] a, b, d;
		for (int c = 0; c < 4; c++) begin
			a = {st_in[c][7:0], st_in[c][31:8]};
			b = {st_in[4+c][22:0], st_in[4+c][31:23]};
			d = st_in[8+c];
			sp[8+c] = a ^ (d << 1) ^ ((b & d) << 2);
			sp[4+c] = b ^ a ^ ((a | d) << 1);
			sp[c]   = d ^ b ^ ((a & b) << 3);
		end
	end

	always_comb begin
		st_out = sp;
		unique case (rnd[1:0])
			2'b00: begin
				st_out[0] = sp[1] ^ (gimli_pkg::RC | 32'(rnd));
				st_out[1] = sp[0];
				st_out[2] = sp[3];
				st_out[3] = sp[2];
			end
			2'b10: begin
				st_out[0] = sp[2];
				st_out[1] = sp[3];
				st_out[2] = sp[0];
				st_out[3] = sp[1];
			end
			default: st_out = sp;
		endcase
	end

endmodule

[sv/gimli_sponge_hash.sv]
// Gimli sponge hash: one message byte per request; every 16th byte adds a
// permutation (one round a cycle in the shared round unit). A last request adds
// the padding permutation (after a permutation of the block if its byte fills
// it), then one digest byte a cycle while m_tready is high, with a permutation
// per further 16-byte block. Asynchronous reset clears the state, fill position
// and sequencer; hash_length resets to 32. Uses gimli_pkg and gimli_round.
module gimli_sponge_hash #(
	parameter int unsigned ROUNDS = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,    // [7:0] msg_byte
	input  logic [0:0]  s_tuser,    // [0] has_byte
	input  logic        s_tlast,    // last_item
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,    // [7:0] digest_byte
	output logic        m_tlast,    // digest_last
	input  logic        cfg_we,
	input  logic [6:0]  cfg_wdata   // hash_length
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_PAD  = 4'b0010,
		ST_PERM = 4'b0100,
		ST_SQZ  = 4'b1000
	} fsm_t;

	localparam logic [gimli_pkg::RND_W-1:0] RND_LOAD = gimli_pkg::RND_W'(ROUNDS);

	fsm_t                               fsm_q, nxt_q;
	gimli_pkg::state_t                  state_q, st_rnd, st_abs;
	logic [3:0]                         fill_q, fill_inc;
	logic [gimli_pkg::RND_W-1:0]        rnd_q;
	logic [gimli_pkg::CNT_W-1:0]        k_q, k_end;
	logic [gimli_pkg::HLEN_W-1:0]       hlen_q, hlen_c;
	logic                               s_acc, m_acc, has;

	gimli_round u_round (
		.st_in  (state_q),
		.rnd    (rnd_q),
		.st_out (st_rnd)
	);

	assign s_tready = (fsm_q == ST_IDLE);
	assign m_tvalid = (fsm_q == ST_SQZ);
	assign s_acc    = s_tvalid && s_tready;
	assign m_acc    = m_tvalid && m_tready;
	assign has      = s_tuser[0];

	assign fill_inc = fill_q + 4'd1;
	assign st_abs   = has ? gimli_pkg::xor_byte(state_q, fill_q, s_tdata) : state_q;

	// digest length clamped to 1..64, held as the index of the final byte
	always_comb begin
		if (hlen_q > gimli_pkg::HLEN_W'(gimli_pkg::MAX_DIG))
			hlen_c = gimli_pkg::HLEN_W'(gimli_pkg::MAX_DIG);
		else if (hlen_q == '0)
			hlen_c = gimli_pkg::HLEN_W'(1);
		else
			hlen_c = hlen_q;
	end
	assign k_end = gimli_pkg::CNT_W'(hlen_c - gimli_pkg::HLEN_W'(1));

	assign m_tdata = state_q[k_q[3:2]][{k_q[1:0], 3'b000} +: 8];
	assign m_tlast = (k_q == k_end);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			hlen_q <= gimli_pkg::HLEN_W'(32);
		else if (cfg_we)
			hlen_q <= cfg_wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsm_q   <= ST_IDLE;
			nxt_q   <= ST_IDLE;
			state_q <= '0;
			fill_q  <= '0;
			rnd_q   <= '0;
			k_q     <= '0;
		end else begin
			unique case (fsm_q)
				ST_IDLE: begin
					if (s_acc) begin
						if (has && fill_q == gimli_pkg::LAST_POS) begin
							// block full: permute, pad afterwards if last
							state_q <= st_abs;
							fill_q  <= '0;
							rnd_q   <= RND_LOAD;
							fsm_q   <= ST_PERM;
							nxt_q   <= s_tlast ? ST_PAD : ST_IDLE;
						end else if (s_tlast) begin
							state_q <= gimli_pkg::pad(st_abs, has ? fill_inc : fill_q);
							rnd_q   <= RND_LOAD;
							fsm_q   <= ST_PERM;
							nxt_q   <= ST_SQZ;
							k_q     <= '0;
						end else if (has) begin
							state_q <= st_abs;
							fill_q  <= fill_inc;
						end
					end
				end
				ST_PAD: begin
					state_q <= gimli_pkg::pad(state_q, fill_q);
					rnd_q   <= RND_LOAD;
					fsm_q   <= ST_PERM;
					nxt_q   <= ST_SQZ;
					k_q     <= '0;
				end
				ST_PERM: begin
					state_q <= st_rnd;
					rnd_q   <= rnd_q - 1'b1;
					if (rnd_q == gimli_pkg::RND_W'(1))
						fsm_q <= nxt_q;
				end
				ST_SQZ: begin
					if (m_acc) begin
						if (k_q == k_end) begin
							state_q <= '0;
							fill_q  <= '0;
							k_q     <= '0;
							fsm_q   <= ST_IDLE;
						end else begin
							k_q <= k_q + 1'b1;
							if (k_q[3:0] == gimli_pkg::LAST_POS) begin
								rnd_q <= RND_LOAD;
								fsm_q <= ST_PERM;
								nxt_q <= ST_SQZ;
							end
						end
					end
				end
				default: fsm_q <= ST_IDLE;
			endcase
		end
	end

endmodule

[sv/gimli_chk.sv]
// Port-level checker for gimli_sponge_hash, bound to the top level.
// Depends only on the top level's ports.
module gimli_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tvalid,
	input logic       s_tready,
	input logic       s_tlast,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic       m_tlast
);

	// never taking a request while a digest byte is on offer
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input ready while digest valid");

	// padding permutation always sits between the last request and the digest
	a_pad_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tlast) |=> !m_tvalid)
		else $error("digest without padding permutation");

	// after the final digest byte the block is ready for the next message
	a_back_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && m_tlast) |=> (s_tready && !m_tvalid))
		else $error("not idle after final digest byte");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
		else $error("stalled digest byte changed");

endmodule

bind gimli_sponge_hash gimli_chk u_chk (.*);
